// ===== rtl/swmq_pkg.sv =====
// shared constants, types and pointer helpers for the sliding window monotonic queue
`default_nettype none
package swmq_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int VAL_W      = 64;
  localparam int POS_W      = 32;
  localparam int WIN_W      = 7;
  localparam int COUNT_W    = 7;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRONT,
    ST_POP,
    ST_PUSH
  } state_e;

  // request from the sequencer to the entry store
  typedef struct packed {
    logic             we;
    ptr_t             waddr;
    logic [VAL_W-1:0] wvalue;
    logic [POS_W-1:0] wpos;
    ptr_t             raddr_val;
    ptr_t             raddr_pos;
  } mem_req_t;

  // registered read data from the entry store
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } mem_rsp_t;

  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t r;
    if (int'(p) + 1 >= WINDOW_MAX) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic ptr_t ptr_prev(ptr_t p);
    ptr_t r;
    if (p == '0) begin
      r = ptr_t'(WINDOW_MAX - 1);
    end else begin
      r = p - ptr_t'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/swmq_in_if.sv =====
// input request channel: sample value and last flag
`default_nettype none
interface swmq_in_if;
  logic                         valid;
  logic                         ready;
  logic [swmq_pkg::VAL_W-1:0]   value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/swmq_out_if.sv =====
// output request channel: deque occupancy and last flag
`default_nettype none
interface swmq_out_if;
  logic                         valid;
  logic                         ready;
  logic [swmq_pkg::COUNT_W-1:0] count;
  logic                         is_last;

  modport source (output valid, output count, output is_last, input ready);
  modport sink   (input valid, input count, input is_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/swmq_cfg_if.sv =====
// configuration write channel for the window length register
`default_nettype none
interface swmq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [swmq_pkg::WIN_W-1:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface
`default_nettype wire

// ===== rtl/swmq_store.sv =====
// entry store: value and position ring memories with registered reads
`default_nettype none
module swmq_store (
  input  wire logic               clk_i,
  input  wire swmq_pkg::mem_req_t req_i,
  output swmq_pkg::mem_rsp_t      rsp_o
);

  logic [swmq_pkg::VAL_W-1:0] val_mem [swmq_pkg::WINDOW_MAX];
  logic [swmq_pkg::POS_W-1:0] pos_mem [swmq_pkg::WINDOW_MAX];
  logic [swmq_pkg::VAL_W-1:0] rd_val_q;
  logic [swmq_pkg::POS_W-1:0] rd_pos_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      val_mem[req_i.waddr] <= req_i.wvalue;
      pos_mem[req_i.waddr] <= req_i.wpos;
    end
    rd_val_q <= val_mem[req_i.raddr_val];
    rd_pos_q <= pos_mem[req_i.raddr_pos];
  end

  assign rsp_o.value = rd_val_q;
  assign rsp_o.pos   = rd_pos_q;

endmodule
`default_nettype wire

// ===== rtl/swmq_ctrl.sv =====
// sequencer with the shared comparator: front expiry, back pops, push and result
`default_nettype none
module swmq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire swmq_pkg::cnt_t     win_i,
  swmq_in_if.sink                 in_i,
  swmq_out_if.source              out_o,
  output swmq_pkg::mem_req_t      req_o,
  input  wire swmq_pkg::mem_rsp_t rsp_i
);

  swmq_pkg::state_e state_q, state_d;
  swmq_pkg::ptr_t   head_q, head_d;
  swmq_pkg::ptr_t   tail_q, tail_d;
  swmq_pkg::cnt_t   occ_q, occ_d;
  swmq_pkg::cnt_t   seen_q, seen_d;
  logic [swmq_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [swmq_pkg::VAL_W-1:0]   v_q, v_d;
  logic                         last_q, last_d;
  logic                         ovalid_q, ovalid_d;
  logic [swmq_pkg::COUNT_W-1:0] ocount_q, ocount_d;
  logic                         olast_q, olast_d;

  logic [swmq_pkg::POS_W-1:0]   age;
  logic [swmq_pkg::VAL_W-1:0]   cmp_a, cmp_b;
  logic                         cmp_gt;
  swmq_pkg::cnt_t               seen_next;
  swmq_pkg::cnt_t               occ_push;
  logic                         emit;
  logic                         can_push;

  // one comparator serves both the expiry test and the back pops
  assign age = pos_q - rsp_i.pos;
  always_comb begin
    if (state_q == swmq_pkg::ST_FRONT) begin
      cmp_a = swmq_pkg::VAL_W'(age);
      cmp_b = swmq_pkg::VAL_W'(win_i) - swmq_pkg::VAL_W'(1);
    end else begin
      cmp_a = v_q;
      cmp_b = rsp_i.value;
    end
  end
  assign cmp_gt = cmp_a > cmp_b;

  assign seen_next = (seen_q < win_i) ? seen_q + swmq_pkg::cnt_t'(1) : seen_q;
  assign emit      = seen_next >= win_i;
  assign occ_push  = (int'(occ_q) < swmq_pkg::WINDOW_MAX) ? occ_q + swmq_pkg::cnt_t'(1)
                                                          : occ_q;
  assign can_push  = !emit || !ovalid_q || out_o.ready;

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    seen_d   = seen_q;
    pos_d    = pos_q;
    v_d      = v_q;
    last_d   = last_q;
    ovalid_d = ovalid_q;
    ocount_d = ocount_q;
    olast_d  = olast_q;
    in_i.ready    = 1'b0;
    req_o.we      = 1'b0;
    req_o.waddr   = tail_q;
    req_o.wvalue  = v_q;
    req_o.wpos    = pos_q;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      swmq_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          v_d     = in_i.value;
          last_d  = in_i.last;
          state_d = swmq_pkg::ST_FRONT;
        end
      end
      swmq_pkg::ST_FRONT: begin
        if (occ_q != '0 && cmp_gt) begin
          head_d = swmq_pkg::ptr_next(head_q);
          occ_d  = occ_q - swmq_pkg::cnt_t'(1);
        end
        state_d = swmq_pkg::ST_POP;
      end
      swmq_pkg::ST_POP: begin
        if (occ_q != '0 && cmp_gt) begin
          tail_d = swmq_pkg::ptr_prev(tail_q);
          occ_d  = occ_q - swmq_pkg::cnt_t'(1);
        end else begin
          state_d = swmq_pkg::ST_PUSH;
        end
      end
      swmq_pkg::ST_PUSH: begin
        // hold here while this sample emits a result and a previous result still waits downstream
        if (can_push) begin
          if (int'(occ_q) < swmq_pkg::WINDOW_MAX) begin
            req_o.we = 1'b1;
            tail_d   = swmq_pkg::ptr_next(tail_q);
          end
          occ_d  = occ_push;
          pos_d  = pos_q + swmq_pkg::POS_W'(1);
          seen_d = seen_next;
          if (emit) begin
            ovalid_d = 1'b1;
            ocount_d = swmq_pkg::COUNT_W'(occ_push);
            olast_d  = last_q;
          end
          if (last_q) begin
            head_d = '0;
            tail_d = '0;
            occ_d  = '0;
            pos_d  = '0;
            seen_d = '0;
          end
          state_d = swmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swmq_pkg::ST_IDLE;
      end
    endcase

    req_o.raddr_val = swmq_pkg::ptr_prev(tail_d);
    req_o.raddr_pos = head_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= swmq_pkg::ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      occ_q    <= '0;
      seen_q   <= '0;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      occ_q    <= occ_d;
      seen_q   <= seen_d;
      pos_q    <= pos_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    last_q   <= last_d;
    ocount_q <= ocount_d;
    olast_q  <= olast_d;
  end

  assign out_o.valid   = ovalid_q;
  assign out_o.count   = ocount_q;
  assign out_o.is_last = olast_q;

endmodule
`default_nettype wire

// ===== rtl/sliding_window_monotonic_queue_unit.sv =====
// Sliding window monotonic queue: top level.
// Takes unsigned 64-bit samples on in_i (value, last) and keeps a deque of
// (position, value) entries whose values never increase from front to back.
// For each sample the front entry is dropped if it left the window, smaller
// entries are popped from the back, and the sample is appended. Once
// window_len samples of the sequence have been seen, out_o carries the deque
// occupancy in count and the sample's last flag in is_last.
// cfg_i writes window_len (0 acts as 1, above 64 acts as 64); write it only
// while the block is idle. It is always ready.
// Each item passes through an accept step, a front check, a back pop loop
// that ends on a closing compare, and a push. The pop loop runs through the
// shared 64-bit comparator, and the entry memories have registered reads.
// The result is registered and shows in the cycle after the push.
// in_i.ready is high only while idle. A waiting result does not block the
// next item; only its push waits, if it emits, while the previous result is not taken.
// Reset sets window_len to 1 and empties the deque; an item with last set
// empties it afterward. The entry memories need no clearing.
`default_nettype none
module sliding_window_monotonic_queue_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  swmq_in_if.sink    in_i,
  swmq_out_if.source out_o,
  swmq_cfg_if.sink   cfg_i
);

  logic [swmq_pkg::WIN_W-1:0] win_len_q;
  swmq_pkg::cnt_t             win_eff;
  swmq_pkg::mem_req_t         mem_req;
  swmq_pkg::mem_rsp_t         mem_rsp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= swmq_pkg::WIN_W'(1);
    end else if (cfg_i.valid) begin
      win_len_q <= cfg_i.window_len;
    end
  end

  // clamp the register to 1..WINDOW_MAX
  always_comb begin
    if (win_len_q == '0) begin
      win_eff = swmq_pkg::cnt_t'(1);
    end else if (int'(win_len_q) > swmq_pkg::WINDOW_MAX) begin
      win_eff = swmq_pkg::cnt_t'(swmq_pkg::WINDOW_MAX);
    end else begin
      win_eff = swmq_pkg::cnt_t'(win_len_q);
    end
  end

  swmq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .win_i  (win_eff),
    .in_i   (in_i),
    .out_o  (out_o),
    .req_o  (mem_req),
    .rsp_i  (mem_rsp)
  );

  swmq_store u_store (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

endmodule
`default_nettype wire

// ===== rtl/swmq_checker.sv =====
// port-level assertions for the sliding window monotonic queue, bound to the top level
`default_nettype none
module swmq_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [swmq_pkg::COUNT_W-1:0] out_count_i,
  input wire logic                         out_is_last_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_count_i) &&
      $stable(out_is_last_i))
    else $error("stalled result changed");

  // the block works on one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after an accepted request");

  // a result's occupancy lies within 1..WINDOW_MAX
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i != '0 && int'(out_count_i) <= swmq_pkg::WINDOW_MAX)
    else $error("result count out of range");

  // a fresh result comes from a push, never while idle
  a_result_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a request in flight");

endmodule

bind sliding_window_monotonic_queue_unit swmq_checker u_swmq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_count_i   (out_o.count),
  .out_is_last_i (out_o.is_last)
);
`default_nettype wire
